/* design/whc_pkg.sv */
// Shared types and codes for the wheel hall rotation counter.
package whc_pkg;

  localparam int unsigned OUT_CNT_W = 16;
  localparam int unsigned NUM_CNT   = 6;

  // Item kind carried on tuser.
  localparam logic MODE_EVENT = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic WHEEL_LEFT  = 1'b0;
  localparam logic WHEEL_RIGHT = 1'b1;

  localparam logic SENSOR_TOP    = 1'b0;
  localparam logic SENSOR_BOTTOM = 1'b1;

  // Pin patterns, also used as sequence states.
  localparam logic [1:0] PAT_NONE   = 2'd0;
  localparam logic [1:0] PAT_BOTTOM = 2'd1;
  localparam logic [1:0] PAT_TOP    = 2'd2;
  localparam logic [1:0] PAT_BOTH   = 2'd3;

  localparam logic [1:0] SEQ_RESET = PAT_BOTTOM;

  // Flight phases that select a counter.
  localparam logic [5:0] PH_TAKEOFF = 6'd0;
  localparam logic [5:0] PH_MID_A   = 6'd2;
  localparam logic [5:0] PH_MID_B   = 6'd5;
  localparam logic [5:0] PH_LANDING = 6'd6;

  // Counter slots, output order: kind * 2 + wheel.
  localparam logic [2:0] CNT_TAKEOFF = 3'd0;
  localparam logic [2:0] CNT_MIDDLE  = 3'd2;
  localparam logic [2:0] CNT_LANDING = 3'd4;

  typedef struct packed {
    logic       mode;
    logic       wheel;
    logic       sensor;
    logic       active;
    logic [5:0] phase;
  } whc_item_t;

  typedef struct packed {
    logic                               stepped;
    logic [NUM_CNT-1:0][OUT_CNT_W-1:0] count;
  } whc_result_t;

  // Expected next pattern for a wheel in a given sequence state.
  function automatic logic [1:0] expected_next(input logic wheel, input logic [1:0] seq);
    logic [1:0] want;
    want = PAT_NONE;
    if (wheel == WHEEL_LEFT) begin
      case (seq)
        PAT_BOTTOM: want = PAT_BOTH;
        PAT_BOTH:   want = PAT_TOP;
        PAT_TOP:    want = PAT_BOTTOM;
        default:    want = PAT_NONE;
      endcase
    end else begin
      case (seq)
        PAT_BOTTOM: want = PAT_TOP;
        PAT_TOP:    want = PAT_BOTH;
        PAT_BOTH:   want = PAT_BOTTOM;
        default:    want = PAT_NONE;
      endcase
    end
    return want;
  endfunction

endpackage

/* design/whc_in_stage.sv */
// Input register stage: holds one accepted item until the core consumes it.
module whc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  whc_pkg::whc_item_t in_item,
  input  logic               advance,
  output logic               in_ready,
  output logic               s1_valid,
  output whc_pkg::whc_item_t s1_item
);
  import whc_pkg::*;

  logic      valid_r, valid_nxt;
  whc_item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* design/whc_core.sv */
// Wheel sequence state, sensor levels and step counters, updated once per item.
module whc_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  whc_pkg::whc_item_t   item,
  output whc_pkg::whc_result_t result
);
  import whc_pkg::*;

  logic [3:0]                              levels_r, levels_nxt;
  logic [1:0][1:0]                         seq_r, seq_nxt;
  logic [1:0][1:0]                         pat_r, pat_nxt;
  logic [NUM_CNT-1:0][COUNT_WIDTH-1:0]     cnt_r, cnt_nxt;

  logic [1:0] bit_idx, other_idx;
  logic [1:0] want;
  logic       stepped;
  logic       cnt_hit;
  logic [2:0] cnt_base;
  logic [2:0] cnt_idx;

  always_comb begin
    bit_idx   = {item.wheel, item.sensor};
    other_idx = {item.wheel, ~item.sensor};
    want      = expected_next(item.wheel, seq_r[item.wheel]);

    cnt_hit  = 1'b1;
    cnt_base = CNT_TAKEOFF;
    if (item.phase == PH_TAKEOFF) begin
      cnt_base = CNT_TAKEOFF;
    end else if (item.phase == PH_MID_A || item.phase == PH_MID_B) begin
      cnt_base = CNT_MIDDLE;
    end else if (item.phase == PH_LANDING) begin
      cnt_base = CNT_LANDING;
    end else begin
      cnt_hit = 1'b0;
    end
    cnt_idx = cnt_base + {2'b00, item.wheel};

    levels_nxt = levels_r;
    seq_nxt    = seq_r;
    pat_nxt    = pat_r;
    cnt_nxt    = cnt_r;
    stepped    = 1'b0;

    if (item.mode == MODE_CLEAR) begin
      cnt_nxt[CNT_TAKEOFF]      = '0;
      cnt_nxt[CNT_TAKEOFF + 3'd1] = '0;
      cnt_nxt[CNT_LANDING]      = '0;
      cnt_nxt[CNT_LANDING + 3'd1] = '0;
    end else if (item.active) begin
      levels_nxt[bit_idx] = 1'b1;
      if (levels_r[other_idx]) begin
        pat_nxt[item.wheel] = PAT_BOTH;
      end else begin
        pat_nxt[item.wheel] = (item.sensor == SENSOR_TOP) ? PAT_TOP : PAT_BOTTOM;
      end
    end else begin
      levels_nxt[bit_idx] = 1'b0;
      // both sensors clear: try to advance
      if (!levels_r[other_idx] && want != PAT_NONE && pat_r[item.wheel] == want) begin
        seq_nxt[item.wheel] = want;
        stepped             = 1'b1;
        for (int i = 0; i < NUM_CNT; i++) begin
          if (cnt_hit && cnt_idx == 3'(i)) begin
            cnt_nxt[i] = cnt_r[i] + COUNT_WIDTH'(1);
          end
        end
      end
    end

    result.stepped = stepped;
    for (int i = 0; i < NUM_CNT; i++) begin
      result.count[i] = OUT_CNT_W'(cnt_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= '0;
      seq_r    <= {SEQ_RESET, SEQ_RESET};
      pat_r    <= {PAT_NONE, PAT_NONE};
      cnt_r    <= '0;
    end else if (fire) begin
      levels_r <= levels_nxt;
      seq_r    <= seq_nxt;
      pat_r    <= pat_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* design/wheel_hall_rotation_counter.sv */
// Top level: two-wheel hall sensor step counter with stream in and out.
// Path from input accept to result valid: input register, then result register.
// Throughput: one item per cycle unless the result stalls (out_tready low).
// A stalled result still lets one more item wait in the input register.
// Reset (rst_n low, synchronous): both stages empty, sequences at 1,
// patterns and levels cleared, all counters zero.
module wheel_hall_rotation_counter #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [0] wheel, [1] sensor, [2] active, [8:3] phase, rest 0
  input  logic         in_tuser,   // [0] mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // [15:0] left_takeoff_count, [31:16] right_takeoff_count,
                                   // [47:32] left_middle_count, [63:48] right_middle_count,
                                   // [79:64] left_landing_count, [95:80] right_landing_count,
                                   // [96] stepped, rest 0
);
  import whc_pkg::*;

  whc_item_t   in_item;
  whc_item_t   s1_item;
  logic        s1_valid;
  logic        advance;
  whc_result_t core_result;

  logic        out_valid_r, out_valid_nxt;
  whc_result_t out_result_r;

  // Unpack the stream payload.
  assign in_item.mode   = in_tuser;
  assign in_item.wheel  = in_tdata[0];
  assign in_item.sensor = in_tdata[1];
  assign in_item.active = in_tdata[2];
  assign in_item.phase  = in_tdata[8:3];

  // The held item moves into the result register when that register is
  // free or being drained this cycle; the core commits its state then.
  assign advance = s1_valid && (!out_valid_r || out_tready);

  whc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_item  (in_item),
    .advance  (advance),
    .in_ready (in_tready),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  whc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item),
    .result (core_result)
  );

  // Result register.
  assign out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_tready) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result_r <= core_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_result_r.stepped,
                       out_result_r.count[5], out_result_r.count[4],
                       out_result_r.count[3], out_result_r.count[2],
                       out_result_r.count[1], out_result_r.count[0]};

endmodule

/* design/whc_checker.sv */
// Port-level checks for the wheel hall rotation counter, bound to the top level.
module whc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Only two items fit: result stalled and an item taken means input full.
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_tvalid && !out_tready && in_tvalid && in_tready)
      && !out_tready |-> !in_tready)
    else $error("input accepted beyond buffer capacity");

  // An item taken with no result held passes the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |-> ##2 out_tvalid)
    else $error("result did not follow accepted item");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[103:97] == 7'b0)
    else $error("nonzero padding in result");

endmodule

bind wheel_hall_rotation_counter whc_checker u_whc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
